FILE: hdl/sbq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Smoothed biquad package
// Shared types, register indexes and saturation helpers for the multichannel
// transposed direct form II biquad core.
// ----------------------------------------------------------------------------
package sbq_pkg;

	localparam int MAX_CHANNELS_DEF   = 8;
	localparam int SAMPLE_BITS_DEF    = 24;
	localparam int COEF_FRAC_BITS_DEF = 27;

	localparam int COEF_BITS  = 32;
	localparam int STATE_BITS = 48;
	localparam int FB_BITS    = 40;
	localparam int NUM_COEFS  = 5;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int SMOOTH_BITS = 17;
	localparam int ACT_BITS    = 4;
	localparam int CH_BITS     = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_TB0    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TB1    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TB2    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TA1    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_TA2    = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SMOOTH = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE = 3'd6;

	localparam logic [SMOOTH_BITS-1:0] SMOOTH_RESET = 17'h10000;
	localparam logic [ACT_BITS-1:0]    ACTIVE_RESET = 4'd2;

	// coefficient slots
	localparam logic [2:0] C_B0 = 3'd0;
	localparam logic [2:0] C_B1 = 3'd1;
	localparam logic [2:0] C_B2 = 3'd2;
	localparam logic [2:0] C_A1 = 3'd3;
	localparam logic [2:0] C_A2 = 3'd4;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_BLEND,
		OP_HI,
		OP_LO
	} op_t;

	typedef struct packed {
		op_t        kind;
		logic [2:0] idx;
	} uop_t;

	localparam logic signed [STATE_BITS-1:0] S48_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
	localparam logic signed [STATE_BITS-1:0] S48_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
	localparam logic signed [FB_BITS-1:0]    S40_MAX = {1'b0, {(FB_BITS-1){1'b1}}};
	localparam logic signed [FB_BITS-1:0]    S40_MIN = {1'b1, {(FB_BITS-1){1'b0}}};

	function automatic logic signed [STATE_BITS-1:0] sat_prod48(input logic signed [75:0] v);
		logic [75:47] top;
		top = v[75:47];
		if ((&top) || !(|top))
			return v[STATE_BITS-1:0];
		return v[75] ? S48_MIN : S48_MAX;
	endfunction

	function automatic logic signed [STATE_BITS-1:0] sat_sum48(input logic signed [51:0] v);
		logic [51:47] top;
		top = v[51:47];
		if ((&top) || !(|top))
			return v[STATE_BITS-1:0];
		return v[51] ? S48_MIN : S48_MAX;
	endfunction

	function automatic logic signed [FB_BITS-1:0] sat40(input logic signed [STATE_BITS-1:0] v);
		logic [47:39] top;
		top = v[47:39];
		if ((&top) || !(|top))
			return v[FB_BITS-1:0];
		return v[47] ? S40_MIN : S40_MAX;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/smoothed_biquad_multichannel_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Smoothed multichannel biquad core
// Transposed direct form II biquad, per-channel delay memory, shared
// coefficient set that snaps to or blends towards target registers.
// ----------------------------------------------------------------------------
// One item at a time: the next input transfer is taken once the result is
//   registered, as in_ready rises together with out_valid.
// All products come from the single shared 33x25 multiplier: ten partial
//   products per filtered sample plus five for a blend, with a two-stage drain.
// Reset clears coefficients, delay valid bits and control; targets reset to 0,
//   smooth factor to full jump, active channel count to 2.
module smoothed_biquad_multichannel_core
	import sbq_pkg::*;
#(
	parameter int MAX_CHANNELS   = MAX_CHANNELS_DEF,
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [CFG_IDX_BITS-1:0]       cfg_index,
	input  wire  [CFG_DATA_BITS-1:0]      cfg_data,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  signed [SAMPLE_BITS-1:0] sample_in,
	input  wire  [CH_BITS-1:0]            channel,
	input  wire                           block_start,
	input  wire                           snap,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic [CH_BITS-1:0]            channel_out,
	output logic                          clipped
);

	localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int ZF  = 40 - SAMPLE_BITS;
	localparam int SHR = (COEF_FRAC_BITS >= 16) ? COEF_FRAC_BITS : 16;
	localparam int SHL = (COEF_FRAC_BITS >= 16) ? 0 : 16 - COEF_FRAC_BITS;

	localparam logic [4:0] ST_BLEND    = 5'd0;
	localparam logic [4:0] ST_FILT     = 5'd5;
	localparam logic [4:0] ST_ISS_END  = 5'd15;
	localparam logic [4:0] ST_FIN_PASS = 5'd6;
	localparam logic [4:0] ST_FIN_ACT  = 5'd17;

	localparam logic signed [51:0] SMAX = (52'sd1 <<< (SAMPLE_BITS - 1)) - 52'sd1;
	localparam logic signed [51:0] SMIN = -SMAX - 52'sd1;
	localparam logic signed [51:0] RND  = 52'sd1 <<< (ZF - 1);

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t state_q;
	logic [4:0] step_q;

	// configuration
	logic signed [COEF_BITS-1:0] tgt_q [NUM_COEFS];
	logic [SMOOTH_BITS-1:0]      smooth_q;
	logic [ACT_BITS-1:0]         act_q;
	logic signed [COEF_BITS-1:0] coef_q [NUM_COEFS];

	// item
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [CH_BITS-1:0]            ch_q;
	logic                          blend_q;
	logic                          act_ok_q;
	logic                          zvld_q;

	// delay memory
	logic signed [STATE_BITS-1:0] mem1 [MAX_CHANNELS];
	logic signed [STATE_BITS-1:0] mem2 [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0]      dvld_q;
	logic signed [STATE_BITS-1:0] z1_q, z2_q;
	logic signed [STATE_BITS-1:0] z1, z2;

	// datapath
	uop_t                         iss_uop;
	uop_t                         uop_s1;
	logic signed [57:0]           prod_s1;
	logic signed [COEF_BITS-1:0]  cold_s1;
	logic signed [71:0]           acc_s2;
	logic signed [STATE_BITS-1:0] term_s2;
	logic                         tvld_s2;
	logic [2:0]                   tidx_s2;
	logic signed [STATE_BITS-1:0] y_q;
	logic signed [48:0]           n1_q;
	logic signed [STATE_BITS-1:0] n2_q;

	logic signed [32:0]        op_a;
	logic signed [24:0]        op_b;
	logic signed [COEF_BITS-1:0] c_sel;
	logic signed [39:0]        xz, yf, v_sel;
	logic [SMOOTH_BITS-1:0]    g;
	logic [4:0]                rel;
	logic signed [71:0]        full;
	logic signed [75:0]        scaled;
	logic signed [51:0]        rsum, rsh;
	logic                      in_fire, fin, fin_fire;
	logic [CW-1:0]             ch_idx_in, ch_idx_q;
	logic                      act_in;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign ch_idx_in = CW'(channel);
	assign ch_idx_q  = CW'(ch_q);
	assign act_in    = ({1'b0, channel} < act_q) && (int'(channel) < MAX_CHANNELS);
	assign fin       = (state_q == S_RUN) && (step_q == (act_ok_q ? ST_FIN_ACT : ST_FIN_PASS));
	assign fin_fire  = fin && (!out_valid || out_ready);

	assign z1 = zvld_q ? z1_q : '0;
	assign z2 = zvld_q ? z2_q : '0;
	assign xz = 40'(x_q) <<< ZF;
	assign yf = sat40(y_q);
	assign g  = smooth_q[16] ? SMOOTH_RESET : smooth_q;

	// issue decode
	assign rel = step_q - ST_FILT;
	always_comb begin
		iss_uop = '{kind: OP_NONE, idx: 3'd0};
		if (state_q == S_RUN) begin
			if (step_q < ST_FILT) begin
				iss_uop = '{kind: OP_BLEND, idx: step_q[2:0]};
			end else if (step_q < ST_ISS_END && act_ok_q) begin
				iss_uop = '{kind: (rel[0] ? OP_LO : OP_HI), idx: rel[3:1]};
			end
		end
	end

	// shared multiplier operands
	always_comb begin
		c_sel = coef_q[iss_uop.idx];
		v_sel = (iss_uop.idx >= C_A1) ? yf : xz;
		unique case (iss_uop.kind)
			OP_BLEND: begin
				op_a = 33'(tgt_q[iss_uop.idx]) - 33'(c_sel);
				op_b = 25'({8'd0, g});
			end
			OP_HI: begin
				op_a = 33'(c_sel);
				op_b = {v_sel[39], v_sel[39:16]};
			end
			OP_LO: begin
				op_a = 33'(c_sel);
				op_b = 25'({9'd0, v_sel[15:0]});
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign full   = acc_s2 + 72'(prod_s1);
	assign scaled = (76'(full) >>> SHR) <<< SHL;
	assign rsum   = 52'(y_q) + RND;
	assign rsh    = rsum >>> ZF;

	// configuration, coefficients and pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				tgt_q[i]  <= '0;
				coef_q[i] <= '0;
			end
			smooth_q <= SMOOTH_RESET;
			act_q    <= ACTIVE_RESET;
			uop_s1   <= '{kind: OP_NONE, idx: 3'd0};
			tvld_s2  <= 1'b0;
			tidx_s2  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_TB0:    tgt_q[0] <= cfg_data;
					REG_TB1:    tgt_q[1] <= cfg_data;
					REG_TB2:    tgt_q[2] <= cfg_data;
					REG_TA1:    tgt_q[3] <= cfg_data;
					REG_TA2:    tgt_q[4] <= cfg_data;
					REG_SMOOTH: smooth_q <= cfg_data[SMOOTH_BITS-1:0];
					REG_ACTIVE: act_q    <= cfg_data[ACT_BITS-1:0];
					default: ;
				endcase
			end
			uop_s1  <= iss_uop;
			tvld_s2 <= (uop_s1.kind == OP_LO);
			tidx_s2 <= uop_s1.idx;
			if (in_fire && snap) begin
				for (int i = 0; i < NUM_COEFS; i++)
					coef_q[i] <= tgt_q[i];
			end else if (uop_s1.kind == OP_BLEND) begin
				coef_q[uop_s1.idx] <= cold_s1 + 32'(prod_s1 >>> 16);
			end
		end
	end

	// multiplier, product assembly and term combination
	always_ff @(posedge clk) begin
		prod_s1 <= 58'(op_a) * 58'(op_b);
		cold_s1 <= c_sel;
		if (uop_s1.kind == OP_HI)
			acc_s2 <= 72'(prod_s1) <<< 16;
		if (uop_s1.kind == OP_LO)
			term_s2 <= sat_prod48(scaled);
		if (tvld_s2) begin
			unique case (tidx_s2)
				C_B0: y_q  <= sat_sum48(52'(term_s2) + 52'(z1));
				C_B1: n1_q <= 49'(term_s2) + 49'(z2);
				C_B2: n2_q <= term_s2;
				C_A1: n1_q <= 49'(sat_sum48(52'(n1_q) - 52'(term_s2)));
				C_A2: n2_q <= sat_sum48(52'(n2_q) - 52'(term_s2));
				default: ;
			endcase
		end
	end

	// delay memory, registered read
	always_ff @(posedge clk) begin
		if (fin_fire && act_ok_q) begin
			mem1[ch_idx_q] <= n1_q[STATE_BITS-1:0];
			mem2[ch_idx_q] <= n2_q;
		end
		if (in_fire) begin
			z1_q <= mem1[ch_idx_in];
			z2_q <= mem2[ch_idx_in];
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			dvld_q      <= '0;
			out_valid   <= 1'b0;
			sample_out  <= '0;
			channel_out <= '0;
			clipped     <= 1'b0;
			x_q         <= '0;
			ch_q        <= '0;
			blend_q     <= 1'b0;
			act_ok_q    <= 1'b0;
			zvld_q      <= 1'b0;
		end else begin
			if (out_valid && out_ready && !fin_fire)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						x_q      <= sample_in;
						ch_q     <= channel;
						blend_q  <= block_start && !snap;
						act_ok_q <= act_in;
						zvld_q   <= act_in && dvld_q[ch_idx_in];
						step_q   <= (block_start && !snap) ? ST_BLEND : ST_FILT;
						state_q  <= S_RUN;
					end
				end
				S_RUN: begin
					if (fin) begin
						if (fin_fire) begin
							out_valid   <= 1'b1;
							channel_out <= ch_q;
							state_q     <= S_IDLE;
							if (!act_ok_q) begin
								sample_out <= x_q;
								clipped    <= 1'b0;
							end else begin
								dvld_q[ch_idx_q] <= 1'b1;
								if (rsh > SMAX) begin
									sample_out <= SMAX[SAMPLE_BITS-1:0];
									clipped    <= 1'b1;
								end else if (rsh < SMIN) begin
									sample_out <= SMIN[SAMPLE_BITS-1:0];
									clipped    <= 1'b1;
								end else begin
									sample_out <= rsh[SAMPLE_BITS-1:0];
									clipped    <= 1'b0;
								end
							end
						end
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> (uop_s1.kind == OP_NONE) && !tvld_s2)
		else $error("result taken with products in flight");

	a_blend_only_when_asked: assert property (@(posedge clk) disable iff (!arst_n)
		(uop_s1.kind == OP_BLEND) |-> blend_q)
		else $error("blend issued without block start");

	a_filter_only_active: assert property (@(posedge clk) disable iff (!arst_n)
		(uop_s1.kind == OP_HI || uop_s1.kind == OP_LO) |-> act_ok_q)
		else $error("filter product issued for pass-through channel");

	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clipped) |->
			(sample_out == SMAX[SAMPLE_BITS-1:0]) || (sample_out == SMIN[SAMPLE_BITS-1:0]))
		else $error("clip flag without saturated sample");

	a_transfer_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == S_RUN))
		else $error("input transfer did not start the sequencer");

endmodule
`default_nettype wire

FILE: verif/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Smoothed multichannel biquad core testbench
// Drives samples and register writes over valid/ready channels and compares
// every result with a bit-exact fixed-point biquad predictor kept in step
// with each transfer: snap and blend updates, pass-through channels,
// saturation, random streams and long output stalls.
// ----------------------------------------------------------------------------
module tb;
	import sbq_pkg::*;

	localparam int SB          = SAMPLE_BITS_DEF;
	localparam int CFB         = COEF_FRAC_BITS_DEF;
	localparam int NCH         = MAX_CHANNELS_DEF;
	localparam int ZF          = 40 - SB;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;

	typedef logic signed [79:0] wide_t;

	typedef struct packed {
		logic [SB-1:0]      smp;
		logic [CH_BITS-1:0] ch;
		logic               clip;
	} result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [SB-1:0]     sample_in = '0;
	logic [CH_BITS-1:0]       channel = '0;
	logic                     block_start = 1'b0;
	logic                     snap = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [SB-1:0]     sample_out;
	logic [CH_BITS-1:0]       channel_out;
	logic                     clipped;

	// predictor state
	logic [COEF_BITS-1:0]   tgt [NUM_COEFS];
	logic [SMOOTH_BITS-1:0] smooth;
	logic [ACT_BITS-1:0]    act_cnt;
	wide_t                  coef_now [NUM_COEFS];
	wide_t                  dly1 [NCH];
	wide_t                  dly2 [NCH];

	result_t pending [$];
	result_t want;
	int      mismatch_cnt = 0;
	int      cycle_cnt = 0;
	bit      src_idle_en = 1'b1;
	bit      sink_idle_en = 1'b1;
	bit      hold_req = 1'b0;
	int      hold_left = 0;

	smoothed_biquad_multichannel_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.channel    (channel),
		.block_start(block_start),
		.snap       (snap),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.channel_out(channel_out),
		.clipped    (clipped)
	);

	always #5 clk = ~clk;

	function automatic wide_t saturate(input wide_t v, input int bits);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic wide_t coef_mul(input wide_t c, input wide_t v);
		return saturate((c * v) >>> CFB, STATE_BITS);
	endfunction

	function automatic result_t run_biquad(input logic signed [SB-1:0] smp,
			input logic [CH_BITS-1:0] ch, input logic bs, input logic sn);
		result_t res;
		wide_t   tw;
		wide_t   step;
		wide_t   xz;
		wide_t   y;
		wide_t   yf;
		wide_t   r;
		wide_t   rs;
		res.smp  = smp;
		res.ch   = ch;
		res.clip = 1'b0;
		if (sn) begin
			for (int k = 0; k < NUM_COEFS; k++)
				coef_now[k] = wide_t'($signed(tgt[k]));
		end else if (bs) begin
			step = wide_t'((smooth > SMOOTH_RESET) ? SMOOTH_RESET : smooth);
			for (int k = 0; k < NUM_COEFS; k++) begin
				tw = wide_t'($signed(tgt[k]));
				coef_now[k] = coef_now[k] + (((tw - coef_now[k]) * step) >>> 16);
			end
		end
		if (ch < act_cnt && ch < NCH) begin
			xz = wide_t'(smp);
			xz = xz <<< ZF;
			y  = saturate(coef_mul(coef_now[C_B0], xz) + dly1[ch], STATE_BITS);
			yf = saturate(y, FB_BITS);
			dly1[ch] = saturate(coef_mul(coef_now[C_B1], xz) - coef_mul(coef_now[C_A1], yf)
				+ dly2[ch], STATE_BITS);
			dly2[ch] = saturate(coef_mul(coef_now[C_B2], xz) - coef_mul(coef_now[C_A2], yf),
				STATE_BITS);
			r  = (y + (wide_t'(1) <<< (ZF - 1))) >>> ZF;
			rs = saturate(r, SB);
			res.clip = (rs != r);
			res.smp  = rs[SB-1:0];
		end
		return res;
	endfunction

	function automatic logic signed [SB-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return {1'b0, {(SB-1){1'b1}}};
			1: return {1'b1, {(SB-1){1'b0}}};
			2: return SB'($urandom_range(0, 255) - 128);
			default: return SB'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_TA2)
			tgt[idx] = data;
		else if (idx == REG_SMOOTH)
			smooth = data[SMOOTH_BITS-1:0];
		else if (idx == REG_ACTIVE)
			act_cnt = data[ACT_BITS-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_sample(input logic signed [SB-1:0] smp, input logic [CH_BITS-1:0] ch,
			input logic bs, input logic sn);
		int gap;
		@(negedge clk);
		gap = (src_idle_en && $urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		sample_in   <= smp;
		channel     <= ch;
		block_start <= bs;
		snap        <= sn;
		do @(posedge clk); while (!in_ready);
		pending.push_back(run_biquad(smp, ch, bs, sn));
	endtask

	// idle the input and let every outstanding result out
	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic test_reset_state();
		push_sample({1'b0, {(SB-1){1'b1}}}, 3'd0, 1'b0, 1'b0);
		push_sample({1'b1, {(SB-1){1'b0}}}, 3'd1, 1'b0, 1'b0);
		push_sample({1'b0, {(SB-1){1'b1}}}, 3'd2, 1'b0, 1'b0);
		push_sample({1'b1, {(SB-1){1'b0}}}, 3'd7, 1'b0, 1'b0);
		push_sample(SB'(-1), 3'd0, 1'b1, 1'b0);
		drain_pipeline();
	endtask

	task automatic test_coefficient_updates();
		// unity gain
		write_reg(REG_TB0, 32'h0800_0000);
		push_sample({1'b0, {(SB-1){1'b1}}}, 3'd0, 1'b0, 1'b1);
		push_sample({1'b1, {(SB-1){1'b0}}}, 3'd1, 1'b0, 1'b0);
		drain_pipeline();
		// extreme targets, snap wins over blend
		write_reg(REG_TB0, 32'h7FFF_FFFF);
		write_reg(REG_TB1, 32'h8000_0000);
		write_reg(REG_TB2, 32'h7FFF_FFFF);
		write_reg(REG_TA1, 32'h8000_0000);
		write_reg(REG_TA2, 32'h7FFF_FFFF);
		write_reg(REG_SMOOTH, 32'h0000_0001);
		push_sample(SB'(1000), 3'd0, 1'b1, 1'b1);
		push_sample({1'b1, {(SB-1){1'b0}}}, 3'd0, 1'b0, 1'b0);
		push_sample({1'b0, {(SB-1){1'b1}}}, 3'd1, 1'b0, 1'b0);
		drain_pipeline();
		// blend with zero, minimum and above-full step
		write_reg(REG_TB0, 32'h0400_0000);
		write_reg(REG_SMOOTH, 32'h0000_0000);
		push_sample(SB'(77), 3'd1, 1'b1, 1'b0);
		drain_pipeline();
		write_reg(REG_SMOOTH, 32'h0000_0001);
		push_sample(SB'(-77), 3'd0, 1'b1, 1'b0);
		drain_pipeline();
		write_reg(REG_SMOOTH, 32'hFFFF_FFFF);
		push_sample(SB'(12345), 3'd1, 1'b1, 1'b0);
		drain_pipeline();
	endtask

	task automatic test_channel_activity();
		// no active channel, blend still applies
		write_reg(REG_ACTIVE, 32'h0000_0000);
		push_sample({1'b0, {(SB-1){1'b1}}}, 3'd0, 1'b1, 1'b0);
		push_sample({1'b1, {(SB-1){1'b0}}}, 3'd7, 1'b0, 1'b0);
		drain_pipeline();
		write_reg(REG_ACTIVE, 32'h0000_0008);
		push_sample(SB'(-3), 3'd7, 1'b0, 1'b0);
		drain_pipeline();
		write_reg(REG_ACTIVE, 32'hFFFF_FFFF);
		push_sample(SB'(100), 3'd7, 1'b0, 1'b1);
		drain_pipeline();
		write_reg(REG_ACTIVE, 32'h0000_0001);
		push_sample(SB'(5), 3'd1, 1'b0, 1'b0);
		push_sample(SB'(5), 3'd0, 1'b0, 1'b0);
		drain_pipeline();
	endtask

	task automatic test_random_streams();
		logic [COEF_BITS-1:0]   val;
		logic [SMOOTH_BITS-1:0] sm;
		logic [ACT_BITS-1:0]    act;
		for (int ph = 0; ph < 5; ph++) begin
			src_idle_en  = (ph != 2);
			sink_idle_en = (ph != 2);
			for (int k = 0; k < NUM_COEFS; k++) begin
				case ($urandom_range(0, 3))
					0: val = $urandom;
					3: val = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
					default: val = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
				endcase
				write_reg(REG_TB0 + 3'(k), val);
			end
			case ($urandom_range(0, 4))
				0: sm = '0;
				1: sm = SMOOTH_RESET;
				2: sm = '1;
				3: sm = 17'd1;
				default: sm = SMOOTH_BITS'($urandom_range(0, 65536));
			endcase
			write_reg(REG_SMOOTH, {15'($urandom), sm});
			act = (ph == 0) ? 4'd8 : 4'($urandom_range(0, 15));
			write_reg(REG_ACTIVE, {28'($urandom), act});
			for (int n = 0; n < 100; n++)
				push_sample(rand_sample(), 3'($urandom_range(0, 7)),
					$urandom_range(0, 7) == 0, $urandom_range(0, 19) == 0);
			drain_pipeline();
		end
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	task automatic test_backpressure();
		write_reg(REG_ACTIVE, 32'h0000_0008);
		hold_req = 1'b1;
		for (int n = 0; n < 40; n++)
			push_sample(rand_sample(), 3'($urandom_range(0, 7)),
				$urandom_range(0, 7) == 0, $urandom_range(0, 19) == 0);
		drain_pipeline();
	endtask

	// result sink: random stalls, plus one long hold on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(sink_idle_en && $urandom_range(0, 99) < 10);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending.size() == 0) begin
				mismatch_cnt++;
				$display("%0t: unexpected transfer, sample %h ch %0d clip %0b", $time,
					sample_out, channel_out, clipped);
			end else begin
				want = pending.pop_front();
				if (sample_out !== want.smp) begin
					mismatch_cnt++;
					$display("%0t: sample_out exp %h got %h", $time, want.smp, sample_out);
				end
				if (channel_out !== want.ch) begin
					mismatch_cnt++;
					$display("%0t: channel_out exp %0d got %0d", $time, want.ch, channel_out);
				end
				if (clipped !== want.clip) begin
					mismatch_cnt++;
					$display("%0t: clipped exp %0b got %0b", $time, want.clip, clipped);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("smoothed_biquad_multichannel_core regression: fail");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < NUM_COEFS; k++) begin
			tgt[k]      = '0;
			coef_now[k] = '0;
		end
		for (int k = 0; k < NCH; k++) begin
			dly1[k] = '0;
			dly2[k] = '0;
		end
		smooth  = SMOOTH_RESET;
		act_cnt = ACTIVE_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_coefficient_updates();
		test_channel_activity();
		test_random_streams();
		test_backpressure();
		drain_pipeline();

		if (mismatch_cnt == 0)
			$display("smoothed_biquad_multichannel_core regression: pass");
		else
			$display("smoothed_biquad_multichannel_core regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
